@@ rtl/core/hcbed_pkg.sv @@
// Package for the HTTP chunked body end detector.
// Holds parser mode codes, byte constants, the size width and the hex digit decoder.
// Depends on nothing.
package hcbed_pkg;

   // Width of the chunk size counter.
   localparam int SIZE_BITS = 32;
   localparam int MODE_BITS = 4;

   // Parser modes.
   localparam logic [MODE_BITS-1:0] M_LEAD       = 4'd0;
   localparam logic [MODE_BITS-1:0] M_DIGITS     = 4'd1;
   localparam logic [MODE_BITS-1:0] M_TRAIL_WS   = 4'd2;
   localparam logic [MODE_BITS-1:0] M_EXT        = 4'd3;
   localparam logic [MODE_BITS-1:0] M_EXT_CR     = 4'd4;
   localparam logic [MODE_BITS-1:0] M_SIZE_CR    = 4'd5;
   localparam logic [MODE_BITS-1:0] M_DATA       = 4'd6;
   localparam logic [MODE_BITS-1:0] M_DATA_CR    = 4'd7;
   localparam logic [MODE_BITS-1:0] M_DATA_LF    = 4'd8;
   localparam logic [MODE_BITS-1:0] M_TRL_FIRST  = 4'd9;
   localparam logic [MODE_BITS-1:0] M_TRL_SECOND = 4'd10;
   localparam logic [MODE_BITS-1:0] M_TRL_SCAN   = 4'd11;
   localparam logic [MODE_BITS-1:0] M_DONE       = 4'd12;
   localparam logic [MODE_BITS-1:0] M_BAD        = 4'd13;

   // Byte constants.
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;

   // Decoded hex digit: ok is set when the byte is a hex digit.
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type d;
      d.ok    = 1'b1;
      d.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d.value = 4'(b - 8'h37);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

@@ rtl/core/http_chunked_body_end_detector_core.sv @@
// Top level of the HTTP chunked body end detector.
// Byte-wide chunked framing parser with a two-entry result queue.
// Depends on hcbed_pkg.

// Usage:
// The req_ channel carries one body byte per item, with req_first_of_body set
// on the first byte of a new body to clear the parser before that byte.
// Every accepted item produces exactly one result item on the rsp_ channel:
// rsp_body_complete and rsp_body_malformed, both sticky until the next body
// start. Once either flag is set, further bytes leave the state unchanged.
// The parser state and the result are computed combinationally in the cycle
// of acceptance; the result is registered into the result queue and presented
// from its head. The block accepts one item per cycle while req_stall is low,
// each accepted byte updating the parser state registers.
// The result queue holds two items, so a byte is still accepted while one
// result waits on a stalled receiver; req_stall rises only when both entries
// are full, and drops again as soon as the receiver takes one.
// A synchronous reset puts the parser at the start of a size line with a
// zero size and empties the result queue.
module http_chunked_body_end_detector_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_body_byte,
   input  logic       req_first_of_body,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_body_complete,
   output logic       rsp_body_malformed
);
   import hcbed_pkg::*;

   // Parser state.
   logic [MODE_BITS-1:0] mode_ff,   mode_in;
   logic [SIZE_BITS-1:0] length_ff, length_in;
   logic [1:0]           flags_ff,  flags_in;   // bit0 digit seen, bit1 'x' allowed
   logic [1:0]           match_ff,  match_in;

   // Result queue.
   logic       head_valid_ff, head_valid_in;
   logic       tail_valid_ff, tail_valid_in;
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;

   logic push;
   logic pop;

   assign req_stall          = tail_valid_ff;
   assign push               = req_valid && !req_stall;
   assign rsp_valid          = head_valid_ff;
   assign pop                = head_valid_ff && !rsp_stall;
   assign rsp_body_complete  = head_ff[1];
   assign rsp_body_malformed = head_ff[0];

   // Next parser state for the byte at the input.
   always_comb begin
      logic [MODE_BITS-1:0] m;
      logic [SIZE_BITS-1:0] len;
      logic [1:0]           fl;
      logic [1:0]           tm;
      logic [7:0]           b;
      logic                 have;
      logic                 want_lf;
      logic                 hit;
      hex_digit_type        hx;

      b  = req_body_byte;
      m  = mode_ff;
      len = length_ff;
      fl = flags_ff;
      tm = match_ff;
      if (req_first_of_body) begin
         m   = M_LEAD;
         len = '0;
         fl  = 2'b00;
         tm  = 2'b00;
      end

      mode_in   = m;
      length_in = len;
      flags_in  = fl;
      match_in  = tm;

      have = fl[0];
      hx   = hex_decode(b);

      // CR LF CR LF matcher step.
      want_lf = tm[0];
      hit     = 1'b0;
      if (b == (want_lf ? CH_LF : CH_CR)) begin
         if (tm == 2'd3) begin
            hit = 1'b1;
         end else begin
            match_in = tm + 2'd1;
         end
      end else begin
         match_in = (b == CH_CR) ? 2'd1 : 2'd0;
      end

      unique case (m)
         M_LEAD, M_DIGITS, M_TRAIL_WS: begin
            match_in = tm;
            if (b == CH_SPACE || b == CH_TAB) begin
               if (m != M_LEAD) begin
                  mode_in = have ? M_TRAIL_WS : M_BAD;
               end
            end else if (b == CH_SEMI || b == CH_CR) begin
               if (!have) begin
                  mode_in = M_BAD;
               end else begin
                  mode_in = (b == CH_SEMI) ? M_EXT : M_SIZE_CR;
               end
            end else if (m == M_TRAIL_WS) begin
               mode_in = M_BAD;
            end else if ((b == CH_X_LO || b == CH_X_UP) && fl[1]) begin
               flags_in = 2'b00;
               mode_in  = M_DIGITS;
            end else if (!hx.ok) begin
               mode_in = M_BAD;
            end else if (len[SIZE_BITS-1 -: 4] != 4'd0) begin
               // The next digit would overflow the size counter.
               mode_in = M_BAD;
            end else begin
               length_in = {len[SIZE_BITS-5:0], hx.value};
               flags_in  = (m == M_LEAD && hx.value == 4'd0) ? 2'b11 : 2'b01;
               mode_in   = M_DIGITS;
            end
         end
         M_SIZE_CR, M_EXT_CR: begin
            match_in = tm;
            if (b == CH_LF) begin
               flags_in = 2'b00;
               if (len == '0) begin
                  match_in = 2'd0;
                  mode_in  = M_TRL_FIRST;
               end else begin
                  mode_in = M_DATA;
               end
            end else if (m == M_SIZE_CR) begin
               mode_in = M_BAD;
            end else if (b != CH_CR) begin
               mode_in = M_EXT;
            end
         end
         M_EXT: begin
            match_in = tm;
            if (b == CH_CR) begin
               mode_in = M_EXT_CR;
            end
         end
         M_DATA: begin
            match_in  = tm;
            length_in = len - SIZE_BITS'(1);
            if (len == SIZE_BITS'(1)) begin
               mode_in = M_DATA_CR;
            end
         end
         M_DATA_CR: begin
            match_in = tm;
            mode_in  = (b == CH_CR) ? M_DATA_LF : M_BAD;
         end
         M_DATA_LF: begin
            match_in = tm;
            if (b == CH_LF) begin
               mode_in   = M_LEAD;
               length_in = '0;
               flags_in  = 2'b00;
            end else begin
               mode_in = M_BAD;
            end
         end
         M_TRL_FIRST: begin
            mode_in = (match_in == 2'd1) ? M_TRL_SECOND : M_TRL_SCAN;
         end
         M_TRL_SECOND: begin
            if (b == CH_LF) begin
               match_in = tm;
               mode_in  = M_DONE;
            end else begin
               mode_in = M_TRL_SCAN;
            end
         end
         M_TRL_SCAN: begin
            if (hit) begin
               mode_in = M_DONE;
            end
         end
         M_DONE: begin
            match_in = tm;
         end
         default: begin
            match_in = tm;
            mode_in  = M_BAD;
         end
      endcase
   end

   // Result queue: pop from the head, push behind whatever remains.
   always_comb begin
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      if (pop) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            tail_valid_in = 1'b0;
         end else begin
            head_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!head_valid_in) begin
            head_in       = {mode_in == M_DONE, mode_in == M_BAD};
            head_valid_in = 1'b1;
         end else begin
            tail_in       = {mode_in == M_DONE, mode_in == M_BAD};
            tail_valid_in = 1'b1;
         end
      end
   end

   // Parser state and queue control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_LEAD;
         length_ff     <= '0;
         flags_ff      <= 2'b00;
         match_ff      <= 2'b00;
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            mode_ff   <= mode_in;
            length_ff <= length_in;
            flags_ff  <= flags_in;
            match_ff  <= match_in;
         end
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   // Queue payload registers.
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the HTTP chunked body end detector core.
// Drives directed and random chunked bodies and checks every result against a local parser
// model or a hand-written expectation. Depends on hcbed_pkg and http_chunked_body_end_detector_core.
`timescale 1ns / 100ps

module testbench;
   import hcbed_pkg::*;

   // Cycles without any accepted item before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 360;

   // One planned body byte, with an optional hand-written expectation.
   typedef struct {
      logic [7:0] b;
      logic       first;
      logic       typed;
      logic       complete;
      logic       malformed;
   } body_byte_row_type;

   typedef struct packed {
      logic complete;
      logic malformed;
   } body_flags_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_body_byte;
   logic       req_first_of_body;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_body_complete;
   logic       rsp_body_malformed;

   // Parser model state.
   logic [MODE_BITS-1:0] pmode;
   logic [SIZE_BITS-1:0] plen;
   logic [1:0]           pflags;
   logic [1:0]           pterm;

   body_byte_row_type byte_plan[$];
   body_flags_type    pending_flags[$];
   int                failures;
   int                quiet_cycles;
   int                send_idle_pct;
   int                recv_stall_pct;

   // Expectation attached to the item now on the input port.
   logic row_typed;
   logic row_complete;
   logic row_malformed;

   http_chunked_body_end_detector_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_body_byte      (req_body_byte),
      .req_first_of_body  (req_first_of_body),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_body_complete  (rsp_body_complete),
      .rsp_body_malformed (rsp_body_malformed)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Size line finished: go to the data, or to the ending after a zero size.
   function automatic void close_size_line();
      pflags = '0;
      if (plen == '0) begin
         pterm = '0;
         pmode = M_TRL_FIRST;
      end else begin
         pmode = M_DATA;
      end
   endfunction

   // Step the CR LF CR LF matcher; returns 1 when the whole sequence is seen.
   function automatic logic match_terminator(input logic [7:0] b);
      logic [7:0] want;
      want = pterm[0] ? CH_LF : CH_CR;
      if (b == want) begin
         if (pterm == 2'd3) begin
            return 1'b1;
         end
         pterm = pterm + 2'd1;
      end else begin
         pterm = (b == CH_CR) ? 2'd1 : 2'd0;
      end
      return 1'b0;
   endfunction

   // Advance the parser model by one byte and return the two flags.
   function automatic body_flags_type advance_parser(input logic [7:0] b, input logic first);
      logic           is_hex;
      logic [3:0]     nib;
      body_flags_type flags;
      if (first) begin
         pmode  = M_LEAD;
         plen   = '0;
         pflags = '0;
         pterm  = '0;
      end
      is_hex = 1'b1;
      nib    = 4'd0;
      if (b >= "0" && b <= "9") begin
         nib = 4'(b - "0");
      end else if (b >= "a" && b <= "f") begin
         nib = 4'(b - "a" + 8'd10);
      end else if (b >= "A" && b <= "F") begin
         nib = 4'(b - "A" + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
      case (pmode)
         M_LEAD, M_DIGITS, M_TRAIL_WS: begin
            if (b == CH_SPACE || b == CH_TAB) begin
               if (pmode != M_LEAD) begin
                  pmode = pflags[0] ? M_TRAIL_WS : M_BAD;
               end
            end else if (b == CH_SEMI || b == CH_CR) begin
               if (!pflags[0]) begin
                  pmode = M_BAD;
               end else begin
                  pmode = (b == CH_SEMI) ? M_EXT : M_SIZE_CR;
               end
            end else if (pmode == M_TRAIL_WS) begin
               pmode = M_BAD;
            end else if ((b == CH_X_LO || b == CH_X_UP) && pflags[1]) begin
               pflags = '0;
               pmode  = M_DIGITS;
            end else if (!is_hex || plen[SIZE_BITS-1 -: 4] != 4'd0) begin
               pmode = M_BAD;
            end else begin
               // A lone leading zero still allows the 0x prefix.
               pflags = (pmode == M_LEAD && nib == 4'd0) ? 2'b11 : 2'b01;
               plen   = {plen[SIZE_BITS-5:0], nib};
               pmode  = M_DIGITS;
            end
         end
         M_SIZE_CR: begin
            if (b == CH_LF) begin
               close_size_line();
            end else begin
               pmode = M_BAD;
            end
         end
         M_EXT: begin
            if (b == CH_CR) begin
               pmode = M_EXT_CR;
            end
         end
         M_EXT_CR: begin
            if (b == CH_LF) begin
               close_size_line();
            end else if (b != CH_CR) begin
               pmode = M_EXT;
            end
         end
         M_DATA: begin
            plen = plen - SIZE_BITS'(1);
            if (plen == '0) begin
               pmode = M_DATA_CR;
            end
         end
         M_DATA_CR: begin
            pmode = (b == CH_CR) ? M_DATA_LF : M_BAD;
         end
         M_DATA_LF: begin
            if (b == CH_LF) begin
               pmode  = M_LEAD;
               plen   = '0;
               pflags = '0;
            end else begin
               pmode = M_BAD;
            end
         end
         M_TRL_FIRST: begin
            void'(match_terminator(b));
            pmode = (pterm == 2'd1) ? M_TRL_SECOND : M_TRL_SCAN;
         end
         M_TRL_SECOND: begin
            if (b == CH_LF) begin
               pmode = M_DONE;
            end else begin
               void'(match_terminator(b));
               pmode = M_TRL_SCAN;
            end
         end
         M_TRL_SCAN: begin
            if (match_terminator(b)) begin
               pmode = M_DONE;
            end
         end
         M_DONE: begin
         end
         default: begin
            pmode = M_BAD;
         end
      endcase
      flags.complete  = (pmode == M_DONE);
      flags.malformed = (pmode == M_BAD);
      return flags;
   endfunction

   function automatic void plan_byte(input logic [7:0] b, input logic first);
      body_byte_row_type r;
      r.b         = b;
      r.first     = first;
      r.typed     = 1'b0;
      r.complete  = 1'b0;
      r.malformed = 1'b0;
      byte_plan.insert(byte_plan.size(), r);
   endfunction

   function automatic void plan_typed(input logic [7:0] b, input logic first,
                                      input logic complete, input logic malformed);
      body_byte_row_type r;
      r.b         = b;
      r.first     = first;
      r.typed     = 1'b1;
      r.complete  = complete;
      r.malformed = malformed;
      byte_plan.insert(byte_plan.size(), r);
   endfunction

   function automatic logic [7:0] ws_byte();
      return $urandom_range(1) ? CH_SPACE : CH_TAB;
   endfunction

   // One size line: optional whitespace, prefix, leading zeros and extension.
   function automatic void plan_size_line(input int unsigned size);
      int unsigned digits;
      int unsigned n;
      int          i;
      logic [3:0]  nib;
      logic [7:0]  c;
      digits = 1;
      n      = size >> 4;
      while (n != 0) begin
         digits++;
         n = n >> 4;
      end
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) plan_byte(ws_byte(), 1'b0);
      if ($urandom_range(5) == 0) begin
         plan_byte("0", 1'b0);
         plan_byte($urandom_range(1) ? CH_X_UP : CH_X_LO, 1'b0);
      end
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) plan_byte("0", 1'b0);
      for (i = int'(digits) - 1; i >= 0; i--) begin
         nib = 4'(size >> (4 * i));
         if (nib < 4'd10) begin
            c = "0" + 8'(nib);
         end else begin
            c = ($urandom_range(1) ? "A" : "a") + 8'(nib) - 8'd10;
         end
         plan_byte(c, 1'b0);
      end
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) plan_byte(ws_byte(), 1'b0);
      // Extension with arbitrary bytes; a CR inside it is never followed by LF.
      if ($urandom_range(3) == 0) begin
         plan_byte(CH_SEMI, 1'b0);
         repeat ($urandom_range(6)) begin
            c = 8'($urandom_range(255));
            plan_byte(c, 1'b0);
            if (c == CH_CR) begin
               plan_byte("q", 1'b0);
            end
         end
      end
      plan_byte(CH_CR, 1'b0);
      plan_byte(CH_LF, 1'b0);
   endfunction

   // A well-formed body with random content, sometimes damaged or cut short.
   function automatic void plan_body();
      int unsigned start;
      int unsigned size;
      int unsigned k;
      logic [7:0]  c;
      start = byte_plan.size();
      repeat ($urandom_range(3)) begin
         size = ($urandom_range(39) == 0) ? $urandom_range(600, 200) : $urandom_range(16, 1);
         plan_size_line(size);
         repeat (size) plan_byte(8'($urandom_range(255)), 1'b0);
         plan_byte(CH_CR, 1'b0);
         plan_byte(CH_LF, 1'b0);
      end
      plan_size_line(0);
      if ($urandom_range(1)) begin
         repeat ($urandom_range(2, 1)) begin
            repeat ($urandom_range(10, 1)) plan_byte(8'($urandom_range(126, 32)), 1'b0);
            plan_byte(CH_CR, 1'b0);
            plan_byte(CH_LF, 1'b0);
         end
      end
      plan_byte(CH_CR, 1'b0);
      plan_byte(CH_LF, 1'b0);
      k = $urandom_range(byte_plan.size() - 1, start + 1);
      if ($urandom_range(4) == 0) begin
         case ($urandom_range(7))
            0:       c = CH_CR;
            1:       c = CH_LF;
            2:       c = CH_SPACE;
            3:       c = "+";
            4:       c = CH_SEMI;
            5:       c = CH_X_LO;
            default: c = 8'($urandom_range(255));
         endcase
         byte_plan[k].b = c;
      end else if ($urandom_range(9) == 0) begin
         byte_plan = byte_plan[0:k-1];
      end
      byte_plan[start].first = 1'b1;
      // Bytes after the end are ignored by the block.
      repeat ($urandom_range(2)) plan_byte(8'($urandom_range(255)), 1'b0);
   endfunction

   task automatic send_row(input body_byte_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid         <= 1'b0;
         req_body_byte     <= 8'($urandom_range(255));
         req_first_of_body <= 1'($urandom_range(1));
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_body_byte     <= r.b;
      req_first_of_body <= r.first;
      row_typed     = r.typed;
      row_complete  = r.complete;
      row_malformed = r.malformed;
      do @(posedge clock); while (req_stall);
   endtask

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Predict each accepted item, check each accepted result, and watch for a hang.
   always @(posedge clock) begin : check_results
      body_flags_type got;
      body_flags_type want;
      logic           moved;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            got   = advance_parser(req_body_byte, req_first_of_body);
            if (row_typed) begin
               got.complete  = row_complete;
               got.malformed = row_malformed;
            end
            pending_flags.insert(pending_flags.size(), got);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_flags.size() == 0) begin
               $error("result item with no expectation pending");
               failures++;
            end else begin
               want = pending_flags.pop_front();
               if (rsp_body_complete !== want.complete) begin
                  $error("body_complete: expected %0b, got %0b",
                         want.complete, rsp_body_complete);
                  failures++;
               end
               if (rsp_body_malformed !== want.malformed) begin
                  $error("body_malformed: expected %0b, got %0b",
                         want.malformed, rsp_body_malformed);
                  failures++;
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin : run
      int phase;
      int idle_pct[4];
      int stall_pct[4];
      idle_pct  = '{0, 51, 0, 12};
      stall_pct = '{0, 0, 51, 12};
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_body_byte     = 8'h00;
      req_first_of_body = 1'b0;
      rsp_stall         = 1'b0;
      row_typed         = 1'b0;
      row_complete      = 1'b0;
      row_malformed     = 1'b0;
      failures          = 0;
      quiet_cycles      = 0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      pmode             = M_LEAD;
      plen              = '0;
      pflags            = '0;
      pterm             = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero chunk followed at once by CR LF completes the body.
      plan_byte("0", 1'b1);
      plan_byte(CH_CR, 1'b0);
      plan_byte(CH_LF, 1'b0);
      plan_byte(CH_CR, 1'b0);
      plan_typed(CH_LF, 1'b0, 1'b1, 1'b0);
      // Completion holds for any later byte.
      plan_typed(8'hFF, 1'b0, 1'b1, 1'b0);
      // The highest byte value cannot start a size.
      plan_typed(8'hFF, 1'b1, 1'b0, 1'b1);
      // A sign in the size.
      plan_typed("-", 1'b1, 1'b0, 1'b1);
      // Empty size before an extension.
      plan_typed(CH_SEMI, 1'b1, 1'b0, 1'b1);
      // Size that is only the prefix.
      plan_byte("0", 1'b1);
      plan_byte(CH_X_UP, 1'b0);
      plan_typed(CH_CR, 1'b0, 1'b0, 1'b1);
      // A control byte other than space or tab in the size.
      plan_typed(8'h00, 1'b1, 1'b0, 1'b1);
      // CR in the size not followed by LF.
      plan_byte("1", 1'b1);
      plan_byte(CH_CR, 1'b0);
      plan_typed("a", 1'b0, 1'b0, 1'b1);
      // Data not followed by CR LF.
      plan_byte("1", 1'b1);
      plan_byte(CH_CR, 1'b0);
      plan_byte(CH_LF, 1'b0);
      plan_byte(8'h00, 1'b0);
      plan_typed("x", 1'b0, 1'b0, 1'b1);
      // One digit more than the size counter holds.
      plan_byte("1", 1'b1);
      repeat (SIZE_BITS / 4 - 1) plan_byte("0", 1'b0);
      plan_typed("0", 1'b0, 1'b0, 1'b1);
      foreach (byte_plan[i]) send_row(byte_plan[i]);

      // Random bodies under each idling pattern.
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_pct[phase];
         recv_stall_pct = stall_pct[phase];
         byte_plan.delete();
         while (byte_plan.size() < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(12, 1)) begin
                  plan_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
               end
            end else begin
               plan_body();
            end
         end
         foreach (byte_plan[i]) send_row(byte_plan[i]);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_flags.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
